/* rtl/pv_pkg.sv */
// shared constants, types and helpers of the polyline voxelizer
package pv_pkg;

    localparam int GRID    = 8;
    localparam int DIMS    = 3;
    localparam int MAX_RES = 36;

    // widths
    localparam int CW    = 32;                      // coordinate, Q16.16
    localparam int SW    = 31;                      // step register
    localparam int DW    = 33;                      // span, magnitude, divisor
    localparam int PW    = 65;                      // product / dividend
    localparam int VW    = 35;                      // signed voxel index before range check
    localparam int KW    = $clog2(GRID + 1);        // plane counter
    localparam int IW    = $clog2(GRID);            // voxel index on one axis
    localparam int RAW   = $clog2(GRID * GRID);     // bitmap row address
    localparam int CNTW  = $clog2(MAX_RES + 1);
    localparam int OUT_W = ((3 * IW + 7) / 8) * 8;
    localparam int MUL_N = DW;
    localparam int DIV_N = PW;
    localparam int ITW   = $clog2(DIV_N + 1);

    // command codes on the input tuser
    localparam logic CMD_POINT = 1'b0;
    localparam logic CMD_START = 1'b1;

    // configuration register indexes
    localparam logic [2:0] REG_ORIGIN_X = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [2:0] REG_STEP_X   = 3'd3;
    localparam logic [2:0] REG_STEP_Y   = 3'd4;
    localparam logic [2:0] REG_STEP_Z   = 3'd5;

    typedef struct packed {
        logic [DIMS-1:0][CW-1:0] origin;
        logic [DIMS-1:0][SW-1:0] step;      // zero already replaced by one
    } t_cfg;

    typedef struct packed {
        logic                    start;
        logic [DIMS-1:0][CW-1:0] pt;
    } t_q_item;

    typedef struct packed {
        logic pop;
        logic boot;
    } t_bk_stat;

    typedef struct packed {
        logic          start;
        logic          mul;
        logic [PW-1:0] a;
        logic [DW-1:0] b;
    } t_ar_req;

    typedef struct packed {
        logic          done;
        logic [PW-1:0] q;
        logic [DW-1:0] r;
    } t_ar_rsp;

    // floor quotient from magnitude quotient, remainder flag and sign
    function automatic logic signed [VW-1:0] floor_q(input logic [DW-1:0] q,
                                                     input logic nz,
                                                     input logic neg);
        logic signed [VW-1:0] t;
        t = $signed({{(VW-DW){1'b0}}, q});
        if (neg) begin
            t = -(t + $signed({{(VW-1){1'b0}}, nz}));
        end
        return t;
    endfunction

endpackage

/* rtl/pv_arith.sv */
// shared serial unit: shift-add multiply and restoring divide, one bit per cycle
module pv_arith (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pv_pkg::t_ar_req  i_req,
    output pv_pkg::t_ar_rsp  o_rsp
);

    logic                     r_busy;
    logic                     r_done;
    logic                     r_mul;
    logic [pv_pkg::ITW-1:0]   r_cnt;
    logic [2*pv_pkg::DW-1:0]  r_prod;
    logic [2*pv_pkg::DW-1:0]  r_mc;
    logic [pv_pkg::DW-1:0]    r_mp;
    logic [pv_pkg::PW-1:0]    r_quo;
    logic [pv_pkg::DW-1:0]    r_rem;
    logic [pv_pkg::DW-1:0]    r_b;
    logic [pv_pkg::DW:0]      rem_sh;
    logic [pv_pkg::DW+1:0]    diff;
    logic                     ge;
    logic [pv_pkg::ITW-1:0]   last_it;

    // one restoring divide step
    always_comb begin
        rem_sh  = {r_rem, r_quo[pv_pkg::PW-1]};
        diff    = {1'b0, rem_sh} - {2'b00, r_b};
        ge      = ~diff[pv_pkg::DW+1];
        last_it = r_mul ? pv_pkg::ITW'(pv_pkg::MUL_N - 1) : pv_pkg::ITW'(pv_pkg::DIV_N - 1);
    end

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_mul  <= i_req.mul;
                r_cnt  <= '0;
                r_prod <= '0;
                r_mc   <= {{pv_pkg::DW{1'b0}}, i_req.a[pv_pkg::DW-1:0]};
                r_mp   <= i_req.b;
                r_quo  <= i_req.a;
                r_rem  <= '0;
                r_b    <= i_req.b;
            end else if (r_busy) begin
                if (r_mul) begin
                    if (r_mp[0]) begin
                        r_prod <= r_prod + r_mc;
                    end
                    r_mc <= r_mc << 1;
                    r_mp <= r_mp >> 1;
                end else begin
                    r_rem <= ge ? diff[pv_pkg::DW-1:0] : rem_sh[pv_pkg::DW-1:0];
                    r_quo <= {r_quo[pv_pkg::PW-2:0], ge};
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == last_it) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // results
    always_comb begin
        o_rsp.done = r_done;
        o_rsp.q    = r_mul ? r_prod[pv_pkg::PW-1:0] : r_quo;
        o_rsp.r    = r_rem;
    end

endmodule

/* rtl/pv_front.sv */
// input side: takes beats, tags start commands and queues them for the back end
module pv_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [3*pv_pkg::CW-1:0]    s_axis_tdata,
    input  logic                       s_axis_tuser,
    input  pv_pkg::t_bk_stat           i_stat,
    output logic                       o_q_valid,
    output pv_pkg::t_q_item            o_q_item
);

    pv_pkg::t_q_item r_q [2];
    logic [1:0]      r_fill;
    logic            push;
    logic            pop;
    pv_pkg::t_q_item in_item;

    // classify the incoming beat
    always_comb begin
        in_item.start = (s_axis_tuser == pv_pkg::CMD_START);
        in_item.pt    = s_axis_tdata;
        s_axis_tready = (r_fill != 2'd2) && !i_stat.boot;
        push          = s_axis_tvalid && s_axis_tready;
        pop           = i_stat.pop && (r_fill != 2'd0);
        o_q_valid     = (r_fill != 2'd0);
        o_q_item      = r_q[0];
    end

    // two entry queue, head always in slot 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= 2'd0;
        end else begin
            r_fill <= r_fill + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_q[0] <= r_q[1];
        end
        if (push) begin
            if (pop) begin
                if (r_fill == 2'd1) begin
                    r_q[0] <= in_item;
                end else begin
                    r_q[1] <= in_item;
                end
            end else if (r_fill == 2'd0) begin
                r_q[0] <= in_item;
            end else begin
                r_q[1] <= in_item;
            end
        end
    end

endmodule

/* rtl/pv_back.sv */
// back end: segment walk over plane crossings, visited bitmap and result staging
module pv_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  pv_pkg::t_cfg               i_cfg,
    input  logic                       i_q_valid,
    input  pv_pkg::t_q_item            i_q_item,
    output pv_pkg::t_bk_stat           o_stat,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [pv_pkg::OUT_W-1:0]   m_axis_tdata,
    output logic                       m_axis_tlast
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CLR    = 4'd1;
    localparam logic [3:0] S_AXIS   = 4'd2;
    localparam logic [3:0] S_WS     = 4'd3;
    localparam logic [3:0] S_WE     = 4'd4;
    localparam logic [3:0] S_KSTART = 4'd5;
    localparam logic [3:0] S_LSTART = 4'd6;
    localparam logic [3:0] S_WMUL   = 4'd7;
    localparam logic [3:0] S_WIDIV  = 4'd8;
    localparam logic [3:0] S_WVDIV  = 4'd9;
    localparam logic [3:0] S_EMIT   = 4'd10;
    localparam logic [3:0] S_CHK    = 4'd11;
    localparam logic [3:0] S_FIN    = 4'd12;

    localparam int ROWS  = pv_pkg::GRID * pv_pkg::GRID;
    localparam int RAW_W = pv_pkg::RAW;

    logic [3:0]                       r_state;
    logic                             r_boot;
    logic [RAW_W-1:0]                 r_clr;
    logic [pv_pkg::CW-1:0]            r_cur  [pv_pkg::DIMS];
    logic [pv_pkg::CW-1:0]            r_prev [pv_pkg::DIMS];
    logic                             r_have_prev;
    logic [1:0]                       r_ax;
    logic [1:0]                       r_l;
    logic                             r_swap;
    logic [pv_pkg::DW-1:0]            r_den;
    logic [pv_pkg::DW-1:0]            r_num;
    logic                             r_neg;
    logic                             r_dneg;
    logic signed [pv_pkg::VW-1:0]     r_s;
    logic [pv_pkg::KW-1:0]            r_k;
    logic [pv_pkg::KW-1:0]            r_klast;
    logic signed [pv_pkg::VW-1:0]     r_vox [pv_pkg::DIMS];
    logic                             r_e2;
    logic [pv_pkg::CNTW-1:0]          r_cnt;
    pv_pkg::t_ar_req                  r_req;
    pv_pkg::t_ar_rsp                  ar_rsp;

    // bitmap memory, one row per (x, y), one bit per z
    logic [pv_pkg::GRID-1:0]          r_map [ROWS];
    logic [pv_pkg::GRID-1:0]          r_rd;
    logic [RAW_W-1:0]                 r_rd_addr;
    logic [pv_pkg::IW-1:0]            r_rd_bit;

    // result staging: hold slot waits to learn whether it is the last one
    logic                             r_hold_v;
    logic [3*pv_pkg::IW-1:0]          r_hold;
    logic                             r_out_v;
    logic [3*pv_pkg::IW-1:0]          r_out;
    logic                             r_out_last;

    logic signed [pv_pkg::CW-1:0]     lo_p [pv_pkg::DIMS];
    logic signed [pv_pkg::CW-1:0]     hi_p [pv_pkg::DIMS];
    logic signed [pv_pkg::CW-1:0]     org_ax;
    logic [pv_pkg::SW-1:0]            stp_ax;
    logic signed [pv_pkg::CW-1:0]     org_l;
    logic [pv_pkg::SW-1:0]            stp_l;
    logic                             swap_now;
    logic signed [pv_pkg::CW-1:0]     lo_now;
    logic signed [pv_pkg::CW-1:0]     hi_now;
    logic signed [pv_pkg::DW-1:0]     den_now;
    logic signed [pv_pkg::DW:0]       n_lo;
    logic signed [pv_pkg::DW:0]       n_hi;
    logic signed [pv_pkg::VW-1:0]     fq;
    logic signed [pv_pkg::VW-1:0]     kfirst;
    logic signed [pv_pkg::VW-1:0]     klast;
    logic signed [pv_pkg::VW:0]       plane;
    logic signed [pv_pkg::VW:0]       num_w;
    logic signed [pv_pkg::DW-1:0]     d_l;
    logic signed [pv_pkg::DW:0]       off;
    logic signed [pv_pkg::DW:0]       c_l;
    logic signed [pv_pkg::DW+1:0]     n_c;
    logic                             in_grid;
    logic [RAW_W-1:0]                 row_addr;
    logic                             out_free;
    logic                             rem_nz;

    // endpoints ordered on the current axis, and per-axis config
    always_comb begin
        for (int i = 0; i < pv_pkg::DIMS; i++) begin
            lo_p[i] = $signed(r_swap ? r_cur[i] : r_prev[i]);
            hi_p[i] = $signed(r_swap ? r_prev[i] : r_cur[i]);
        end
        org_ax   = $signed(i_cfg.origin[r_ax]);
        stp_ax   = i_cfg.step[r_ax];
        org_l    = $signed(i_cfg.origin[r_l]);
        stp_l    = i_cfg.step[r_l];
        swap_now = $signed(r_cur[r_ax]) < $signed(r_prev[r_ax]);
        lo_now   = $signed(swap_now ? r_cur[r_ax] : r_prev[r_ax]);
        hi_now   = $signed(swap_now ? r_prev[r_ax] : r_cur[r_ax]);
        den_now  = pv_pkg::DW'(hi_now) - pv_pkg::DW'(lo_now);
        n_lo     = (pv_pkg::DW+1)'(lo_now) - (pv_pkg::DW+1)'(org_ax);
        n_hi     = (pv_pkg::DW+1)'(hi_p[r_ax]) - (pv_pkg::DW+1)'(org_ax);
        rem_nz   = (ar_rsp.r != '0);
        fq       = pv_pkg::floor_q(ar_rsp.q[pv_pkg::DW-1:0], rem_nz, r_neg);
        kfirst   = (r_s + 1 < 1) ? pv_pkg::VW'(1) : r_s + 1;
        klast    = (fq > pv_pkg::VW'(pv_pkg::GRID - 1)) ? pv_pkg::VW'(pv_pkg::GRID - 1) : fq;
        plane    = (pv_pkg::VW+1)'(org_ax)
                 + $signed({1'b0, (pv_pkg::VW)'(stp_ax) * (pv_pkg::VW)'(r_k)});
        num_w    = plane - (pv_pkg::VW+1)'(lo_p[r_ax]);
        d_l      = pv_pkg::DW'(hi_p[r_l]) - pv_pkg::DW'(lo_p[r_l]);
        off      = (pv_pkg::DW+1)'(pv_pkg::floor_q(ar_rsp.q[pv_pkg::DW-1:0], rem_nz, r_dneg));
        c_l      = (pv_pkg::DW+1)'(lo_p[r_l]) + off;
        n_c      = (pv_pkg::DW+2)'(c_l) - (pv_pkg::DW+2)'(org_l);
        in_grid  = (r_cnt < pv_pkg::CNTW'(pv_pkg::MAX_RES));
        for (int i = 0; i < pv_pkg::DIMS; i++) begin
            if (r_vox[i] < 0 || r_vox[i] >= pv_pkg::VW'(pv_pkg::GRID)) begin
                in_grid = 1'b0;
            end
        end
        row_addr = RAW_W'(r_vox[0][pv_pkg::IW-1:0]) * RAW_W'(pv_pkg::GRID)
                 + RAW_W'(r_vox[1][pv_pkg::IW-1:0]);
        out_free = !r_out_v || m_axis_tready;
        o_stat.pop  = (r_state == S_IDLE) && i_q_valid;
        o_stat.boot = r_boot;
    end

    // bitmap memory port
    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT) begin
            r_rd <= r_map[row_addr];
        end
        if (r_state == S_CLR) begin
            r_map[r_clr] <= '0;
        end else if (r_state == S_CHK && !r_rd[r_rd_bit] && (!r_hold_v || out_free)) begin
            r_map[r_rd_addr] <= r_rd | (pv_pkg::GRID'(1) << r_rd_bit);
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_boot      <= 1'b1;
            r_clr       <= '0;
            r_have_prev <= 1'b0;
            r_hold_v    <= 1'b0;
            r_out_v     <= 1'b0;
            r_cnt       <= '0;
            r_e2        <= 1'b0;
            r_req.start <= 1'b0;
        end else begin
            r_req.start <= 1'b0;
            if (r_out_v && m_axis_tready) begin
                r_out_v <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        for (int i = 0; i < pv_pkg::DIMS; i++) begin
                            r_cur[i] <= i_q_item.pt[i];
                        end
                        r_cnt   <= '0;
                        r_ax    <= 2'd0;
                        r_e2    <= 1'b0;
                        if (i_q_item.start) begin
                            r_have_prev <= 1'b0;
                            r_clr       <= '0;
                            r_state     <= S_CLR;
                        end else if (!r_have_prev) begin
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_AXIS;
                        end
                    end
                end
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == RAW_W'(ROWS - 1)) begin
                        r_boot  <= 1'b0;
                        r_state <= r_boot ? S_IDLE : S_FIN;
                    end
                end
                S_AXIS: begin
                    if (den_now == '0) begin
                        r_state <= (r_ax == 2'd2) ? S_FIN : S_AXIS;
                        r_ax    <= r_ax + 1'b1;
                    end else begin
                        r_swap      <= swap_now;
                        r_den       <= den_now;
                        r_neg       <= n_lo[pv_pkg::DW];
                        r_req.start <= 1'b1;
                        r_req.mul   <= 1'b0;
                        r_req.a     <= pv_pkg::PW'(n_lo[pv_pkg::DW] ? -n_lo : n_lo);
                        r_req.b     <= pv_pkg::DW'(stp_ax);
                        r_state     <= S_WS;
                    end
                end
                S_WS: begin
                    if (ar_rsp.done) begin
                        r_s         <= fq;
                        r_neg       <= n_hi[pv_pkg::DW];
                        r_req.start <= 1'b1;
                        r_req.mul   <= 1'b0;
                        r_req.a     <= pv_pkg::PW'(n_hi[pv_pkg::DW] ? -n_hi : n_hi);
                        r_req.b     <= pv_pkg::DW'(stp_ax);
                        r_state     <= S_WE;
                    end
                end
                S_WE: begin
                    if (ar_rsp.done) begin
                        if (kfirst > klast) begin
                            r_state <= (r_ax == 2'd2) ? S_FIN : S_AXIS;
                            r_ax    <= r_ax + 1'b1;
                        end else begin
                            r_k     <= kfirst[pv_pkg::KW-1:0];
                            r_klast <= klast[pv_pkg::KW-1:0];
                            r_state <= S_KSTART;
                        end
                    end
                end
                S_KSTART: begin
                    r_num       <= num_w[pv_pkg::DW-1:0];
                    r_vox[r_ax] <= $signed({{(pv_pkg::VW-pv_pkg::KW){1'b0}}, r_k});
                    r_l         <= 2'd0;
                    r_state     <= S_LSTART;
                end
                S_LSTART: begin
                    if (r_l == r_ax) begin
                        r_l     <= r_l + 1'b1;
                        r_state <= (r_l == 2'd2) ? S_EMIT : S_LSTART;
                    end else begin
                        r_dneg      <= d_l[pv_pkg::DW-1];
                        r_req.start <= 1'b1;
                        r_req.mul   <= 1'b1;
                        r_req.a     <= pv_pkg::PW'(d_l[pv_pkg::DW-1] ? -d_l : d_l);
                        r_req.b     <= r_num;
                        r_state     <= S_WMUL;
                    end
                end
                S_WMUL: begin
                    if (ar_rsp.done) begin
                        r_req.start <= 1'b1;
                        r_req.mul   <= 1'b0;
                        r_req.a     <= ar_rsp.q;
                        r_req.b     <= r_den;
                        r_state     <= S_WIDIV;
                    end
                end
                S_WIDIV: begin
                    if (ar_rsp.done) begin
                        r_neg       <= n_c[pv_pkg::DW+1];
                        r_req.start <= 1'b1;
                        r_req.mul   <= 1'b0;
                        r_req.a     <= pv_pkg::PW'(n_c[pv_pkg::DW+1] ? -n_c : n_c);
                        r_req.b     <= pv_pkg::DW'(stp_l);
                        r_state     <= S_WVDIV;
                    end
                end
                S_WVDIV: begin
                    if (ar_rsp.done) begin
                        r_vox[r_l] <= fq;
                        r_l        <= r_l + 1'b1;
                        r_state    <= (r_l == 2'd2) ? S_EMIT : S_LSTART;
                    end
                end
                S_EMIT: begin
                    r_rd_addr <= row_addr;
                    r_rd_bit  <= r_vox[2][pv_pkg::IW-1:0];
                    if (in_grid) begin
                        r_state <= S_CHK;
                    end else if (!r_e2) begin
                        r_e2        <= 1'b1;
                        r_vox[r_ax] <= $signed({{(pv_pkg::VW-pv_pkg::KW){1'b0}}, r_k}) - 1;
                    end else begin
                        r_e2    <= 1'b0;
                        r_k     <= r_k + 1'b1;
                        r_state <= (r_k != r_klast) ? S_KSTART
                                 : ((r_ax == 2'd2) ? S_FIN : S_AXIS);
                        if (r_k == r_klast) begin
                            r_ax <= r_ax + 1'b1;
                        end
                    end
                end
                S_CHK: begin
                    if (r_rd[r_rd_bit] || !r_hold_v || out_free) begin
                        if (!r_rd[r_rd_bit]) begin
                            if (r_hold_v) begin
                                r_out      <= r_hold;
                                r_out_last <= 1'b0;
                                r_out_v    <= 1'b1;
                            end
                            r_hold   <= {r_vox[2][pv_pkg::IW-1:0], r_vox[1][pv_pkg::IW-1:0],
                                         r_vox[0][pv_pkg::IW-1:0]};
                            r_hold_v <= 1'b1;
                            r_cnt    <= r_cnt + 1'b1;
                        end
                        r_state <= S_EMIT;
                        if (!r_e2) begin
                            r_e2        <= 1'b1;
                            r_vox[r_ax] <= $signed({{(pv_pkg::VW-pv_pkg::KW){1'b0}}, r_k}) - 1;
                        end else begin
                            r_e2    <= 1'b0;
                            r_k     <= r_k + 1'b1;
                            r_state <= (r_k != r_klast) ? S_KSTART
                                     : ((r_ax == 2'd2) ? S_FIN : S_AXIS);
                            if (r_k == r_klast) begin
                                r_ax <= r_ax + 1'b1;
                            end
                        end
                    end
                end
                S_FIN: begin
                    if (!r_hold_v || out_free) begin
                        if (r_hold_v) begin
                            r_out      <= r_hold;
                            r_out_last <= 1'b1;
                            r_out_v    <= 1'b1;
                            r_hold_v   <= 1'b0;
                        end
                        for (int i = 0; i < pv_pkg::DIMS; i++) begin
                            r_prev[i] <= r_cur[i];
                        end
                        r_have_prev <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    pv_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req),
        .o_rsp   (ar_rsp)
    );

    // master side
    always_comb begin
        m_axis_tvalid = r_out_v;
        m_axis_tdata  = pv_pkg::OUT_W'(r_out);
        m_axis_tlast  = r_out_last;
    end

endmodule

/* rtl/polyline_voxelizer_unit.sv */
// top level of the polyline voxelizer: config registers, front end and back end
//
// Each accepted point closes a segment with the point before it (a start command begins a
// new curve instead); for every interior grid plane that segment crosses, the two voxels
// touching the crossing are sent out if inside the grid, each once per curve and at most
// 36 per point (a visited bitmap of 64 rows x 8 bits filters repeats). A start command
// clears the bitmap and gives no beat; after reset the same clear runs with s_axis_tready
// low. Work per point is set by the one shared serial arithmetic unit: two divides per
// axis the segment spans, plus, per plane crossing, a multiply and two divides for each
// of the two other axes, plus a bitmap check per voxel. A two-beat queue lets the input
// run ahead, and a hold slot and a result register let results wait while the output
// stalls.
module polyline_voxelizer_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // config write port
    input  logic                          i_cfg_we,
    input  logic [2:0]                    i_cfg_idx,
    input  logic [pv_pkg::CW-1:0]         i_cfg_wdata,
    // input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [3*pv_pkg::CW-1:0]       s_axis_tdata,   // point_x, point_y, point_z
    input  logic                          s_axis_tuser,   // cmd
    // result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [pv_pkg::OUT_W-1:0]      m_axis_tdata,   // voxel_x, voxel_y, voxel_z, zero pad
    output logic                          m_axis_tlast    // last
);

    logic [pv_pkg::CW-1:0] r_origin [pv_pkg::DIMS];
    logic [pv_pkg::SW-1:0] r_step   [pv_pkg::DIMS];
    pv_pkg::t_cfg          cfg;
    pv_pkg::t_bk_stat      bk_stat;
    logic                  q_valid;
    pv_pkg::t_q_item       q_item;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < pv_pkg::DIMS; i++) begin
                r_origin[i] <= '0;
                r_step[i]   <= pv_pkg::SW'(65536);
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pv_pkg::REG_ORIGIN_X: r_origin[0] <= i_cfg_wdata;
                pv_pkg::REG_ORIGIN_Y: r_origin[1] <= i_cfg_wdata;
                pv_pkg::REG_ORIGIN_Z: r_origin[2] <= i_cfg_wdata;
                pv_pkg::REG_STEP_X:   r_step[0]   <= i_cfg_wdata[pv_pkg::SW-1:0];
                pv_pkg::REG_STEP_Y:   r_step[1]   <= i_cfg_wdata[pv_pkg::SW-1:0];
                pv_pkg::REG_STEP_Z:   r_step[2]   <= i_cfg_wdata[pv_pkg::SW-1:0];
                default: begin
                end
            endcase
        end
    end

    // zero step behaves as one
    always_comb begin
        for (int i = 0; i < pv_pkg::DIMS; i++) begin
            cfg.origin[i] = r_origin[i];
            cfg.step[i]   = (r_step[i] == '0) ? pv_pkg::SW'(1) : r_step[i];
        end
    end

    pv_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_stat        (bk_stat),
        .o_q_valid     (q_valid),
        .o_q_item      (q_item)
    );

    pv_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_q_valid     (q_valid),
        .i_q_item      (q_item),
        .o_stat        (bk_stat),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

/* rtl/pv_checker.sv */
// port-level checks of the polyline voxelizer, bound to the top level
module pv_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       s_axis_tready,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [pv_pkg::OUT_W-1:0]   m_axis_tdata,
    input logic                       m_axis_tlast
);

    // a result beat stays until taken
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    // a stalled result keeps its payload
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result payload changed while stalled");

    // no result beat right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result beat after reset");

    // bitmap clear holds off input right after reset
    a_boot_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("input accepted during bitmap clear");

endmodule

bind polyline_voxelizer_unit pv_checker u_pv_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

/* verif/polyline_voxelizer_checker.sv */
// checker for the polyline voxelizer: models the block, compares every result beat
`timescale 1ns / 100ps

module polyline_voxelizer_checker (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [2:0]               i_cfg_idx,
    input  logic [pv_pkg::CW-1:0]    i_cfg_wdata,
    input  logic                     s_axis_tvalid,
    input  logic                     s_axis_tready,
    input  logic [3*pv_pkg::CW-1:0]  s_axis_tdata,   // point_x, point_y, point_z
    input  logic                     s_axis_tuser,   // cmd
    input  logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    input  logic [pv_pkg::OUT_W-1:0] m_axis_tdata,   // voxel_x, voxel_y, voxel_z, zero pad
    input  logic                     m_axis_tlast,   // last
    output int                       o_pending,
    output int                       o_errors,
    output int                       o_points,
    output int                       o_voxels
);
    import pv_pkg::*;

    localparam int NVOX = GRID * GRID * GRID;

    typedef struct {
        logic [2:0] vx;
        logic [2:0] vy;
        logic [2:0] vz;
        logic       last;
    } voxel_t;

    // model copy of the config and curve state
    longint          grid_origin [DIMS];
    longint          grid_step   [DIMS];
    longint          prev_pt     [DIMS];
    bit              have_prev;
    bit [NVOX-1:0]   visited;
    voxel_t          voxel_fifo[$];

    function automatic longint floor_div(longint num, longint den);
        longint q;
        q = num / den;
        if ((num % den) != 0 && num < 0)
            q = q - 1;
        return q;
    endfunction

    // mark and queue one voxel if it is inside the grid, new on this curve and the list holds fewer than MAX_RES
    function automatic void mark_voxel(longint vox [DIMS], ref voxel_t lst[$]);
        voxel_t v;
        int     idx;
        if (lst.size() >= MAX_RES)
            return;
        for (int a = 0; a < DIMS; a++)
            if (vox[a] < 0 || vox[a] >= GRID)
                return;
        idx = int'(vox[0] * GRID * GRID + vox[1] * GRID + vox[2]);
        if (visited[idx])
            return;
        visited[idx] = 1'b1;
        v.vx   = vox[0][2:0];
        v.vy   = vox[1][2:0];
        v.vz   = vox[2][2:0];
        v.last = 1'b0;
        lst.push_back(v);
    endfunction

    // voxels crossed by the segment from the previous point to this one
    function automatic void voxelize_point(logic cmd, logic [3*CW-1:0] data);
        longint cur [DIMS];
        longint lo [DIMS];
        longint hi [DIMS];
        longint vox [DIMS];
        longint den, s, e, kfirst, klast, plane, num, d, off, c;
        longint unsigned mag, prod, q, r;
        voxel_t lst[$];
        for (int a = 0; a < DIMS; a++)
            cur[a] = longint'($signed(data[a*CW +: CW]));
        if (cmd == CMD_START) begin
            visited   = '0;
            have_prev = 1'b0;
        end
        if (have_prev) begin
            for (int ax = 0; ax < DIMS; ax++) begin
                if (cur[ax] < prev_pt[ax]) begin
                    lo = cur;
                    hi = prev_pt;
                end else begin
                    lo = prev_pt;
                    hi = cur;
                end
                den = hi[ax] - lo[ax];
                if (den <= 0)
                    continue;
                s = floor_div(lo[ax] - grid_origin[ax], grid_step[ax]);
                e = floor_div(hi[ax] - grid_origin[ax], grid_step[ax]);
                kfirst = (s + 1 < 1) ? 1 : s + 1;
                klast  = (e > GRID - 1) ? GRID - 1 : e;
                for (longint k = kfirst; k <= klast; k++) begin
                    plane = grid_origin[ax] + grid_step[ax] * k;
                    num   = plane - lo[ax];
                    for (int l = 0; l < DIMS; l++) begin
                        if (l == ax) begin
                            vox[l] = k;
                            continue;
                        end
                        d    = hi[l] - lo[l];
                        mag  = (d < 0) ? -d : d;
                        prod = mag * longint'(num);
                        q    = prod / longint'(den);
                        r    = prod % longint'(den);
                        if (d >= 0)
                            off = q;
                        else
                            off = -longint'(q + (r != 0 ? 1 : 0));
                        c = lo[l] + off;
                        vox[l] = floor_div(c - grid_origin[l], grid_step[l]);
                    end
                    mark_voxel(vox, lst);
                    vox[ax] = k - 1;
                    mark_voxel(vox, lst);
                end
            end
        end
        prev_pt   = cur;
        have_prev = 1'b1;
        if (lst.size() > 0)
            lst[lst.size()-1].last = 1'b1;
        foreach (lst[i])
            voxel_fifo.push_back(lst[i]);
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        o_errors++;
    endtask

    initial begin
        o_pending = 0;
        o_errors  = 0;
        o_points  = 0;
        o_voxels  = 0;
    end

    always @(posedge i_clk) begin
        voxel_t exp_v;
        if (!i_rst_n) begin
            for (int a = 0; a < DIMS; a++) begin
                grid_origin[a] = 0;
                grid_step[a]   = 65536;
                prev_pt[a]     = 0;
            end
            have_prev = 1'b0;
            visited   = '0;
            voxel_fifo.delete();
        end else begin
            // result beat against the oldest expected voxel
            if (m_axis_tvalid && m_axis_tready) begin
                o_voxels++;
                if (voxel_fifo.size() == 0) begin
                    report("unexpected voxel beat, x", m_axis_tdata[2:0], 0);
                end else begin
                    exp_v = voxel_fifo.pop_front();
                    if (m_axis_tdata[2:0] != exp_v.vx)
                        report("voxel_x", m_axis_tdata[2:0], exp_v.vx);
                    if (m_axis_tdata[5:3] != exp_v.vy)
                        report("voxel_y", m_axis_tdata[5:3], exp_v.vy);
                    if (m_axis_tdata[8:6] != exp_v.vz)
                        report("voxel_z", m_axis_tdata[8:6], exp_v.vz);
                    if (m_axis_tlast != exp_v.last)
                        report("last", m_axis_tlast, exp_v.last);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                o_points++;
                voxelize_point(s_axis_tuser, s_axis_tdata);
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ORIGIN_X, REG_ORIGIN_Y, REG_ORIGIN_Z:
                        grid_origin[i_cfg_idx] = longint'($signed(i_cfg_wdata));
                    REG_STEP_X, REG_STEP_Y, REG_STEP_Z: begin
                        grid_step[i_cfg_idx - REG_STEP_X] = i_cfg_wdata[SW-1:0];
                        if (i_cfg_wdata[SW-1:0] == 0)
                            grid_step[i_cfg_idx - REG_STEP_X] = 1;
                    end
                    default: ;
                endcase
            end
        end
        // expected beats still owed by the block
        o_pending = voxel_fifo.size();
    end

endmodule

/* verif/polyline_voxelizer_unit_test.sv */
// testbench top of the polyline voxelizer: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module polyline_voxelizer_unit_test;
    import pv_pkg::*;

    localparam int U          = 65536;
    localparam int STALL_MAX  = 100000;
    localparam int DRAIN_WAIT = 24000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [2:0]           i_cfg_idx = REG_ORIGIN_X;
    logic [CW-1:0]        i_cfg_wdata = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [3*CW-1:0]      s_axis_tdata = '0;   // point_x, point_y, point_z
    logic                 s_axis_tuser = CMD_POINT;   // cmd
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b1;
    logic [OUT_W-1:0]     m_axis_tdata;        // voxel_x, voxel_y, voxel_z, zero pad
    logic                 m_axis_tlast;        // last
    int                   pending, errors, points, voxels;
    int                   burst_left = 0;
    int                   idle_cnt = 0;
    longint               cur_origin [DIMS];
    longint               cur_step [DIMS];

    polyline_voxelizer_unit dut (.*);

    polyline_voxelizer_checker chk (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_wdata,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
        .o_pending(pending), .o_errors(errors), .o_points(points), .o_voxels(voxels)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // receiver: phases of always ready, coin flip and mostly stalled
    initial begin
        int mode, len;
        forever begin
            mode = $urandom_range(0, 2);
            len  = $urandom_range(10, 200);
            repeat (len) begin
                @(negedge i_clk);
                case (mode)
                    0: m_axis_tready = 1'b1;
                    1: m_axis_tready = $urandom_range(0, 1);
                    default: m_axis_tready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // watchdog on cycles with no beat on either stream
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt > STALL_MAX) begin
            $display("timeout: no beat for %0d cycles", idle_cnt);
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [CW-1:0] val);
        i_cfg_we    = 1'b1;
        i_cfg_idx   = idx;
        i_cfg_wdata = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx <= REG_ORIGIN_Z)
            cur_origin[idx] = longint'($signed(val));
        else
            cur_step[idx - REG_STEP_X] = (val[SW-1:0] == 0) ? 1 : val[SW-1:0];
    endtask

    task automatic set_grid(logic [CW-1:0] org, logic [CW-1:0] stp);
        write_reg(REG_ORIGIN_X, org);
        write_reg(REG_ORIGIN_Y, org + stp);
        write_reg(REG_ORIGIN_Z, org - stp);
        write_reg(REG_STEP_X, stp);
        write_reg(REG_STEP_Y, stp);
        write_reg(REG_STEP_Z, stp);
    endtask

    // sends one point beat; keeps tvalid up inside a burst
    task automatic send_point(logic cmd, logic [CW-1:0] x, logic [CW-1:0] y,
                              logic [CW-1:0] z);
        s_axis_tuser  = cmd;
        s_axis_tdata  = {z, y, x};
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(0, 12)) @(negedge i_clk);
            burst_left = $urandom_range(0, 6);
        end
    endtask

    // queued points may still be walking with no beat to show for it
    task automatic wait_idle();
        s_axis_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    // coordinate mostly near the grid, sometimes anywhere
    function automatic logic [CW-1:0] rand_coord(int axis);
        longint v;
        if ($urandom_range(0, 7) == 0)
            return $urandom;
        v = cur_origin[axis] + (longint'($urandom_range(0, 10240)) - 1024) * cur_step[axis] / 1024;
        return v[CW-1:0];
    endfunction

    task automatic random_points(int n);
        logic cmd;
        repeat (n) begin
            cmd = ($urandom_range(0, 9) == 0) ? CMD_START : CMD_POINT;
            send_point(cmd, rand_coord(0), rand_coord(1), rand_coord(2));
        end
    endtask

    initial begin
        for (int a = 0; a < DIMS; a++) begin
            cur_origin[a] = 0;
            cur_step[a]   = U;
        end
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part with the reset grid
        send_point(CMD_POINT, U/2, U/2, U/2);
        send_point(CMD_POINT, 15*U/2, 15*U/2, 15*U/2);
        send_point(CMD_POINT, 15*U/2, 15*U/2, 15*U/2);
        send_point(CMD_START, 0, 0, 0);
        send_point(CMD_POINT, 2*U, 0, 0);
        send_point(CMD_POINT, U/2, 3*U, 0);
        send_point(CMD_POINT, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
        send_point(CMD_POINT, 32'h80000000, 32'h7fffffff, 32'h80000000);
        send_point(CMD_START, -U, -U, 9*U);
        send_point(CMD_POINT, 9*U, 9*U, -U);
        send_point(CMD_START, 0, 0, 0);
        send_point(CMD_POINT, 8*U, 8*U, 8*U);
        send_point(CMD_POINT, 0, 8*U, 3*U + 1);
        send_point(CMD_POINT, 7*U + 1, 1, 8*U - 1);
        send_point(CMD_START, 4*U, 4*U, 4*U);
        send_point(CMD_POINT, 4*U, 4*U, 4*U);
        send_point(CMD_POINT, 4*U - 1, 4*U + 1, 5*U);
        random_points(20);
        wait_idle();

        // finer grid with negative origin
        set_grid(-3*U, U/2);
        random_points(25);
        wait_idle();

        // minimum step
        set_grid(32'h00001000, 1);
        random_points(20);
        wait_idle();

        // largest step, lowest origin
        set_grid(32'h80000000, 32'h7fffffff);
        random_points(20);
        wait_idle();

        // zero step acts as one, near-highest origin and mixed axes
        set_grid(32'h7ffffff0, 32'h80000000);
        write_reg(REG_STEP_Y, 3*U);
        write_reg(REG_ORIGIN_Z, 32'hfff00000);
        random_points(20);
        wait_idle();

        $display("sent %0d point beats over five grid settings, checked %0d voxel beats",
                 points, voxels);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* files.f */
rtl/pv_pkg.sv
rtl/pv_arith.sv
rtl/pv_front.sv
rtl/pv_back.sv
rtl/polyline_voxelizer_unit.sv
rtl/pv_checker.sv
verif/polyline_voxelizer_checker.sv
verif/polyline_voxelizer_unit_test.sv
